// ----- rtl/assert_macros.svh -----
// Assertion macros for the files that check their own behaviour.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define ASSERT_SAME(label, clk, rst, ante, cons, msg)
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

// ----- rtl/mlr_pkg.sv -----
// Shared types and constants of the line rasteriser.
`timescale 1ns / 1ps
package mlr_pkg;

   localparam int MAX_PIXELS = 64;
   localparam int CNT_BITS   = $clog2(MAX_PIXELS);

   // Slope cases, named after the axis that is stepped and the sign of dy.
   typedef enum logic [1:0] {
      SLOPE_SHALLOW_UP = 2'd0,
      SLOPE_SHALLOW_DN = 2'd1,
      SLOPE_STEEP_DN   = 2'd2,
      SLOPE_STEEP_UP   = 2'd3
   } slope_type;

   typedef struct packed {
      logic load;
      logic setup;
      logic step;
   } dp_cmd_type;

   typedef struct packed {
      logic last;
   } dp_sts_type;

endpackage

// ----- rtl/mlr_dp.sv -----
// Datapath of the line rasteriser: endpoint ordering, setup and pixel stepping.
`timescale 1ns / 1ps
module mlr_dp #(
   parameter int COORD_BITS = 6
) (
   input  logic                   clock,
   input  mlr_pkg::dp_cmd_type    cmd,
   input  logic [COORD_BITS-1:0]  start_x,
   input  logic [COORD_BITS-1:0]  start_y,
   input  logic [COORD_BITS-1:0]  end_x,
   input  logic [COORD_BITS-1:0]  end_y,
   output logic [COORD_BITS-1:0]  pixel_x,
   output logic [COORD_BITS-1:0]  pixel_y,
   output mlr_pkg::dp_sts_type    sts
);
   import mlr_pkg::*;

   // The error term stays within a few times the coordinate range.
   localparam int EW = COORD_BITS + 4;

   logic [COORD_BITS-1:0] ax_ff, ay_ff, bx_ff, by_ff;
   logic [COORD_BITS-1:0] ax_in, ay_in, bx_in, by_in;
   logic [COORD_BITS-1:0] x_ff, y_ff, x_in, y_in;
   logic signed [EW-1:0]  err_ff, err_in;
   logic signed [EW-1:0]  inc_min_ff, inc_min_in, inc_maj_ff, inc_maj_in;
   slope_type             slope_ff, slope_in;
   logic [CNT_BITS-1:0]   cnt_ff, cnt_in;

   logic signed [EW-1:0]  dx_s, dy_s, major_s, err_init;
   logic                  minor;
   slope_type             slope_new;

   assign dx_s = EW'(bx_ff) - EW'(ax_ff);
   assign dy_s = EW'(by_ff) - EW'(ay_ff);

   always_comb begin
      if (dy_s > 0 && dy_s <= dx_s) begin
         slope_new = SLOPE_SHALLOW_UP;
      end else if (dy_s <= 0 && dy_s >= -dx_s) begin
         slope_new = SLOPE_SHALLOW_DN;
      end else if (dy_s < -dx_s) begin
         slope_new = SLOPE_STEEP_DN;
      end else begin
         slope_new = SLOPE_STEEP_UP;
      end
   end

   always_comb begin
      case (slope_new)
         SLOPE_SHALLOW_UP: begin
            err_init   = dx_s - dy_s - dy_s;
            inc_min_in = dx_s + dx_s - dy_s - dy_s;
            inc_maj_in = -(dy_s + dy_s);
            major_s    = dx_s;
         end
         SLOPE_SHALLOW_DN: begin
            err_init   = -dx_s - dy_s - dy_s;
            inc_min_in = -(dx_s + dx_s) - dy_s - dy_s;
            inc_maj_in = -(dy_s + dy_s);
            major_s    = dx_s;
         end
         SLOPE_STEEP_DN: begin
            err_init   = -dy_s - dx_s - dx_s;
            inc_min_in = -(dx_s + dx_s) - dy_s - dy_s;
            inc_maj_in = -(dx_s + dx_s);
            major_s    = -dy_s;
         end
         default: begin
            err_init   = dy_s - dx_s - dx_s;
            inc_min_in = dy_s + dy_s - dx_s - dx_s;
            inc_maj_in = -(dx_s + dx_s);
            major_s    = dy_s;
         end
      endcase
   end

   // The falling shallow case steps its minor axis on a positive error.
   assign minor = (slope_ff == SLOPE_SHALLOW_DN) ? (err_ff > 0) : (err_ff < 0);

   always_comb begin
      ax_in    = ax_ff;
      ay_in    = ay_ff;
      bx_in    = bx_ff;
      by_in    = by_ff;
      x_in     = x_ff;
      y_in     = y_ff;
      err_in   = err_ff;
      slope_in = slope_ff;
      cnt_in   = cnt_ff;
      if (cmd.load) begin
         if (start_x > end_x) begin
            ax_in = end_x;
            ay_in = end_y;
            bx_in = start_x;
            by_in = start_y;
         end else begin
            ax_in = start_x;
            ay_in = start_y;
            bx_in = end_x;
            by_in = end_y;
         end
      end
      if (cmd.setup) begin
         x_in     = ax_ff;
         y_in     = ay_ff;
         err_in   = err_init;
         slope_in = slope_new;
         if (major_s > EW'(MAX_PIXELS - 1)) begin
            cnt_in = CNT_BITS'(MAX_PIXELS - 1);
         end else begin
            cnt_in = major_s[CNT_BITS-1:0];
         end
      end else if (cmd.step) begin
         cnt_in = cnt_ff - 1'b1;
         err_in = err_ff + (minor ? inc_min_ff : inc_maj_ff);
         case (slope_ff)
            SLOPE_SHALLOW_UP: begin
               x_in = x_ff + 1'b1;
               if (minor) y_in = y_ff + 1'b1;
            end
            SLOPE_SHALLOW_DN: begin
               x_in = x_ff + 1'b1;
               if (minor) y_in = y_ff - 1'b1;
            end
            SLOPE_STEEP_DN: begin
               y_in = y_ff - 1'b1;
               if (minor) x_in = x_ff + 1'b1;
            end
            default: begin
               y_in = y_ff + 1'b1;
               if (minor) x_in = x_ff + 1'b1;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      ax_ff    <= ax_in;
      ay_ff    <= ay_in;
      bx_ff    <= bx_in;
      by_ff    <= by_in;
      x_ff     <= x_in;
      y_ff     <= y_in;
      err_ff   <= err_in;
      slope_ff <= slope_in;
      cnt_ff   <= cnt_in;
      if (cmd.setup) begin
         inc_min_ff <= inc_min_in;
         inc_maj_ff <= inc_maj_in;
      end
   end

   assign pixel_x  = x_ff;
   assign pixel_y  = y_ff;
   assign sts.last = (cnt_ff == '0);

endmodule

// ----- rtl/mlr_ctrl.sv -----
// Controller of the line rasteriser: accept, setup and pixel emission states.
`timescale 1ns / 1ps
module mlr_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   input  mlr_pkg::dp_sts_type  sts,
   output mlr_pkg::dp_cmd_type  cmd
);
   import mlr_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_SETUP = 3'b010,
      ST_RUN   = 3'b100
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      req_tready = 1'b0;
      rsp_tvalid = 1'b0;
      cmd        = '0;
      state_in   = state_ff;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) state_in = ST_SETUP;
         end
         ST_SETUP: begin
            cmd.setup = 1'b1;
            state_in  = ST_RUN;
         end
         ST_RUN: begin
            rsp_tvalid = 1'b1;
            cmd.step   = rsp_tready;
            // The next line may be taken in on the beat of the final pixel.
            if (rsp_tready && sts.last) begin
               req_tready = 1'b1;
               state_in   = req_tvalid ? ST_SETUP : ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      cmd.load = req_tvalid && req_tready;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ----- rtl/midpoint_line_rasterizer.sv -----
// Top level of the midpoint line rasteriser.
// An accepted line passes through the setup state before its first pixel is shown.
// Each line takes a setup step, then one pixel per cycle while rsp_tready is high
// (at most 64 pixels), stepped by the single error-term register in the datapath.
// A new line is taken in on the beat of the previous line's final pixel.
// Reset (synchronous, active high) returns the controller to idle; no result is pending.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module midpoint_line_rasterizer #(
   parameter int COORD_BITS = 6
) (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   // start_x, start_y, end_x, end_y from the lowest bit up
   input  logic [((4 * COORD_BITS + 7) / 8) * 8 - 1:0] req_tdata,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   // pixel_x, pixel_y from the lowest bit up
   output logic [((2 * COORD_BITS + 7) / 8) * 8 - 1:0] rsp_tdata,
   output logic rsp_tlast
);
   import mlr_pkg::*;

   localparam int OW = ((2 * COORD_BITS + 7) / 8) * 8;

   dp_cmd_type            cmd;
   dp_sts_type            sts;
   logic [COORD_BITS-1:0] pixel_x, pixel_y;

   mlr_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   mlr_dp #(
      .COORD_BITS (COORD_BITS)
   ) u_dp (
      .clock   (clock),
      .cmd     (cmd),
      .start_x (req_tdata[COORD_BITS-1:0]),
      .start_y (req_tdata[2*COORD_BITS-1:COORD_BITS]),
      .end_x   (req_tdata[3*COORD_BITS-1:2*COORD_BITS]),
      .end_y   (req_tdata[4*COORD_BITS-1:3*COORD_BITS]),
      .pixel_x (pixel_x),
      .pixel_y (pixel_y),
      .sts     (sts)
   );

   assign rsp_tdata = OW'({pixel_y, pixel_x});
   assign rsp_tlast = sts.last;

   // A line is only taken in while a pixel is pending if that pixel is the final one and leaves.
   `ASSERT_SAME(a_accept_on_last, clock, reset, req_tready && rsp_tvalid,
      rsp_tlast && rsp_tready, "line accepted while pixels of the previous line remain")
   // The cycle after a line is accepted is spent on setup, so no pixel is shown.
   `ASSERT_NEXT(a_setup_gap, clock, reset, req_tvalid && req_tready, !rsp_tvalid,
      "pixel shown during setup")
   // A pixel that is not the final one is always followed by another.
   `ASSERT_NEXT(a_run_continues, clock, reset, rsp_tvalid && rsp_tready && !rsp_tlast,
      rsp_tvalid, "line ended before its final pixel")

endmodule

// ----- verif/midpoint_line_rasterizer_tb.sv -----
// Self-checking testbench for the midpoint line rasteriser: directed and random lines.
`timescale 1ns / 1ps
module midpoint_line_rasterizer_tb;
   import mlr_pkg::*;

   localparam int COORD_BITS  = 6;
   localparam int COORD_MAX   = (1 << COORD_BITS) - 1;
   localparam int REQ_W       = ((4 * COORD_BITS + 7) / 8) * 8;
   localparam int RSP_W       = ((2 * COORD_BITS + 7) / 8) * 8;
   localparam int N_DIRECTED  = 22;
   localparam int N_RANDOM    = 158;
   localparam int DRAIN_WAIT  = 2 * (MAX_PIXELS + 2);
   localparam int CYCLE_LIMIT = 600000;

   typedef logic [COORD_BITS-1:0] coord_type;

   typedef struct {
      coord_type x;
      coord_type y;
      logic      last;
   } pixel_type;

   // A line request; where known_pixel is set, the single expected pixel is given directly.
   typedef struct {
      coord_type sx;
      coord_type sy;
      coord_type ex;
      coord_type ey;
      bit        known_pixel;
      coord_type px;
      coord_type py;
   } line_row_type;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_tvalid = 1'b0;
   logic             req_tready;
   logic [REQ_W-1:0] req_tdata = '0;
   logic             rsp_tvalid;
   logic             rsp_tready = 1'b0;
   logic [RSP_W-1:0] rsp_tdata;
   logic             rsp_tlast;

   pixel_type pixel_q[$];
   int     error_count    = 0;
   int     cycle_count    = 0;
   int     send_idle_pct  = 15;
   int     recv_idle_pct  = 77;

   line_row_type directed_lines [N_DIRECTED] = '{
      // Single points.
      '{0, 0, 0, 0, 1'b1, 0, 0},
      '{63, 63, 63, 63, 1'b1, 63, 63},
      '{42, 21, 42, 21, 1'b1, 42, 21},
      // Vertical lines, upward and downward; equal x is never swapped.
      '{10, 3, 10, 60, 1'b0, 0, 0},
      '{10, 60, 10, 3, 1'b0, 0, 0},
      // Flat lines, in both orders.
      '{0, 7, 63, 7, 1'b0, 0, 0},
      '{63, 7, 0, 7, 1'b0, 0, 0},
      // Full diagonals.
      '{0, 0, 63, 63, 1'b0, 0, 0},
      '{0, 63, 63, 0, 1'b0, 0, 0},
      '{63, 63, 0, 0, 1'b0, 0, 0},
      // One line per slope case, plus a falling shallow line given in reverse order.
      '{0, 0, 63, 20, 1'b0, 0, 0},
      '{0, 40, 63, 10, 1'b0, 0, 0},
      '{3, 63, 20, 0, 1'b0, 0, 0},
      '{3, 0, 20, 63, 1'b0, 0, 0},
      '{60, 5, 1, 50, 1'b0, 0, 0},
      // Error term starting at zero in each slope case.
      '{0, 0, 4, 2, 1'b0, 0, 0},
      '{0, 0, 2, 4, 1'b0, 0, 0},
      '{0, 4, 2, 0, 1'b0, 0, 0},
      '{0, 2, 4, 0, 1'b0, 0, 0},
      // Near-vertical and near-flat lines.
      '{62, 1, 61, 63, 1'b0, 0, 0},
      '{0, 0, 1, 63, 1'b0, 0, 0},
      '{0, 0, 63, 1, 1'b0, 0, 0}
   };

   midpoint_line_rasterizer #(
      .COORD_BITS(COORD_BITS)
   ) u_top (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tlast (rsp_tlast)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   task automatic report_mismatch(input string msg);
      $display("MISMATCH at cycle %0d: %s", cycle_count, msg);
      error_count++;
   endtask

   // Queues every pixel of the line between the two endpoints, in drawing order.
   function automatic void rasterise_line(input coord_type sx, input coord_type sy,
                                          input coord_type ex, input coord_type ey);
      int x0, y0, x1, y1, t, dx, dy, err, total, n, x, y;
      slope_type slope;
      pixel_type pix;
      x0 = sx;
      y0 = sy;
      x1 = ex;
      y1 = ey;
      if (x0 > x1) begin
         t = x0; x0 = x1; x1 = t;
         t = y0; y0 = y1; y1 = t;
      end
      dx = x1 - x0;
      dy = y1 - y0;
      if (dy > 0 && dy <= dx) slope = SLOPE_SHALLOW_UP;
      else if (dy >= -dx && dy <= 0) slope = SLOPE_SHALLOW_DN;
      else if (dy < -dx) slope = SLOPE_STEEP_DN;
      else slope = SLOPE_STEEP_UP;
      case (slope)
         SLOPE_SHALLOW_UP: begin total = dx + 1;  err = dx - 2 * dy;  end
         SLOPE_SHALLOW_DN: begin total = dx + 1;  err = -dx - 2 * dy; end
         SLOPE_STEEP_DN:   begin total = -dy + 1; err = -dy - 2 * dx; end
         default:          begin total = dy + 1;  err = dy - 2 * dx;  end
      endcase
      n = (total > MAX_PIXELS) ? MAX_PIXELS : total;
      x = x0;
      y = y0;
      for (int i = 0; i < n; i++) begin
         pix.x    = coord_type'(x);
         pix.y    = coord_type'(y);
         pix.last = (i == n - 1);
         pixel_q.push_back(pix);
         case (slope)
            SLOPE_SHALLOW_UP: begin
               x++;
               if (err < 0) begin y++; err += 2 * dx - 2 * dy; end
               else err -= 2 * dy;
            end
            SLOPE_SHALLOW_DN: begin
               x++;
               if (err > 0) begin y--; err += -2 * dx - 2 * dy; end
               else err -= 2 * dy;
            end
            SLOPE_STEEP_DN: begin
               y--;
               if (err < 0) begin x++; err -= 2 * dx + 2 * dy; end
               else err -= 2 * dx;
            end
            default: begin
               y++;
               if (err < 0) begin x++; err += 2 * dy - 2 * dx; end
               else err -= 2 * dx;
            end
         endcase
      end
   endfunction

   // Called at a rising edge; returns at the edge where the request beat is taken.
   task automatic send_line(input line_row_type row);
      pixel_type pix;
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {row.ey, row.ex, row.sy, row.sx};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      if (row.known_pixel) begin
         pix.x    = row.px;
         pix.y    = row.py;
         pix.last = 1'b1;
         pixel_q.push_back(pix);
      end else begin
         rasterise_line(row.sx, row.sy, row.ex, row.ey);
      end
   endtask

   function automatic coord_type clamp_coord(input int v);
      if (v < 0) return '0;
      if (v > COORD_MAX) return coord_type'(COORD_MAX);
      return coord_type'(v);
   endfunction

   // Unconstrained lines half the time, with short, axis-aligned and diagonal ones mixed in.
   function automatic line_row_type random_line();
      line_row_type row;
      int d;
      row = '{default: '0};
      row.sx = coord_type'($urandom_range(COORD_MAX));
      row.sy = coord_type'($urandom_range(COORD_MAX));
      row.ex = coord_type'($urandom_range(COORD_MAX));
      row.ey = coord_type'($urandom_range(COORD_MAX));
      case ($urandom_range(9))
         5, 6: begin
            row.ex = clamp_coord(int'(row.sx) + int'($urandom_range(8)) - 4);
            row.ey = clamp_coord(int'(row.sy) + int'($urandom_range(8)) - 4);
         end
         7: row.ex = row.sx;
         8: row.ey = row.sy;
         9: begin
            d = $urandom_range(COORD_MAX);
            row.sx = coord_type'($urandom_range(COORD_MAX - d));
            row.ex = coord_type'(int'(row.sx) + d);
            if ($urandom_range(1)) begin
               row.sy = coord_type'($urandom_range(COORD_MAX - d));
               row.ey = coord_type'(int'(row.sy) + d);
            end else begin
               row.sy = coord_type'(d + $urandom_range(COORD_MAX - d));
               row.ey = coord_type'(int'(row.sy) - d);
            end
         end
         default: ;
      endcase
      return row;
   endfunction

   // Result side: check each pixel beat, then choose whether to stall next cycle.
   always @(posedge clock) begin
      pixel_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pixel_q.size() == 0) begin
            report_mismatch($sformatf("unexpected pixel (%0d,%0d) last=%0b",
                                      rsp_tdata[COORD_BITS-1:0],
                                      rsp_tdata[2*COORD_BITS-1:COORD_BITS], rsp_tlast));
         end else begin
            want = pixel_q.pop_front();
            if (rsp_tdata[COORD_BITS-1:0] !== want.x)
               report_mismatch($sformatf("pixel_x got %0d want %0d",
                                         rsp_tdata[COORD_BITS-1:0], want.x));
            if (rsp_tdata[2*COORD_BITS-1:COORD_BITS] !== want.y)
               report_mismatch($sformatf("pixel_y got %0d want %0d",
                                         rsp_tdata[2*COORD_BITS-1:COORD_BITS], want.y));
            if (rsp_tlast !== want.last)
               report_mismatch($sformatf("last got %0b want %0b at (%0d,%0d)",
                                         rsp_tlast, want.last, want.x, want.y));
            if (rsp_tdata[RSP_W-1:2*COORD_BITS] !== '0)
               report_mismatch($sformatf("padding bits not zero: %h", rsp_tdata));
         end
      end
      rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int i = 0; i < N_DIRECTED; i++) send_line(directed_lines[i]);

      for (int i = 0; i < N_RANDOM; i++) begin
         if (i == N_RANDOM / 3) begin
            send_idle_pct = 77;
            recv_idle_pct = 15;
         end else if (i == 2 * N_RANDOM / 3) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         send_line(random_line());
      end
      req_tvalid <= 1'b0;

      while (pixel_q.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);

      if (error_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
